>>> rtl/core/pfa_pkg.sv
// Package for the page frame allocator: operation codes, status codes,
// frame state kinds and the sequencer state type. No dependencies.
package pfa_pkg;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_FREE_ALL = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_POOL_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BAD_ADDRESS = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOC   = 3'd3;
  localparam logic [2:0] ST_BAD_OWNER   = 3'd4;

  // Kind of a frame, kept in the top bits of its status entry.
  localparam logic [1:0] FS_FREE    = 2'd0;
  localparam logic [1:0] FS_UNOWNED = 2'd1;
  localparam logic [1:0] FS_OWNED   = 2'd2;

  localparam int FRAME_SHIFT = 12;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ALLOC = 8'b0000_0100,
    S_LINK  = 8'b0000_1000,
    S_FREE  = 8'b0001_0000,
    S_PUSH  = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

endpackage

>>> rtl/core/pfa_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/page_frame_allocator.sv
// Page frame allocator: LIFO free list of frames with per-owner doubly linked lists.
// Depends on pfa_pkg and pfa_ram.
// Path of a transaction: allocate runs S_ALLOC, then S_LINK when the owner list was not
// empty; free runs S_FREE and S_PUSH; free_all walks the list in S_WALK, one frame per cycle.
// One transaction at a time: the input reopens as the result is registered, so the block
// takes no new transaction before it is through with the last; output stalls hold S_RESP.
// Reset: asynchronous; afterwards a clearing pass over every frame initialises
// the RAMs, during which no transaction is accepted (configuration writes are).
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 1024,
  parameter int NUM_OWNERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [4:0] owner_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] page_address_o,
  output logic [2:0]  status_o,
  output logic [10:0] pages_freed_o
);

  localparam int IW = $clog2(NUM_FRAMES);
  localparam int LW = $clog2(NUM_FRAMES + 1);
  localparam int OW = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
  localparam int SW = 2 + OW;
  localparam logic [LW-1:0] NIL = LW'(NUM_FRAMES);

  state_e state_q, state_d;
  logic [31:0]   pool_base_q;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] owner_head_q [NUM_OWNERS];
  logic [LW-1:0] owner_head_d [NUM_OWNERS];
  logic [IW-1:0] clr_q, clr_d;
  logic [IW-1:0] f_q, f_d;
  logic [OW-1:0] o_q, o_d;
  logic          owned_q, owned_d;
  logic [LW-1:0] h_q, h_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [31:0]   res_page_q, res_page_d;
  logic [2:0]    res_status_q, res_status_d;
  logic [10:0]   res_freed_q, res_freed_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_page_q, out_page_d;
  logic [2:0]    out_status_q, out_status_d;
  logic [10:0]   out_freed_q, out_freed_d;

  // RAM ports
  logic          nx_we, pv_we, st_we;
  logic [IW-1:0] nx_waddr, pv_waddr, st_waddr;
  logic [LW-1:0] nx_wdata, pv_wdata;
  logic [SW-1:0] st_wdata;
  logic [IW-1:0] nx_raddr, pv_raddr, st_raddr;
  logic [LW-1:0] nx_rdata, pv_rdata;
  logic [SW-1:0] st_rdata;

  // Input decode
  logic          own_none, own_ok;
  logic [31:0]   owner_ext;
  logic [OW-1:0] oidx;
  logic [32:0]   offset;
  logic          in_pool;
  logic [IW-1:0] frame;
  logic [LW-1:0] head, cnt_inc;

  assign own_none  = (owner_i == -5'sd1);
  assign owner_ext = {28'd0, owner_i[3:0]};
  assign own_ok    = !owner_i[4] && (owner_ext < NUM_OWNERS);
  assign oidx      = owner_ext[OW-1:0];
  // Borrow out of the subtract flags an address below the pool.
  assign offset    = {1'b0, address_i} - {1'b0, pool_base_q};
  assign in_pool   = !offset[32] && ({12'd0, offset[31:12]} < NUM_FRAMES);
  assign frame     = offset[FRAME_SHIFT +: IW];
  assign head      = owner_head_q[oidx];
  assign cnt_inc   = cnt_q + LW'(1);

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_page_q;
  assign status_o       = out_status_q;
  assign pages_freed_o  = out_freed_q;

  always_comb begin
    state_d      = state_q;
    free_head_d  = free_head_q;
    owner_head_d = owner_head_q;
    clr_d        = clr_q;
    f_d          = f_q;
    o_d          = o_q;
    owned_d      = owned_q;
    h_d          = h_q;
    cnt_d        = cnt_q;
    res_page_d   = res_page_q;
    res_status_d = res_status_q;
    res_freed_d  = res_freed_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_page_d   = out_page_q;
    out_status_d = out_status_q;
    out_freed_d  = out_freed_q;
    nx_we = 1'b0; nx_waddr = f_q; nx_wdata = NIL; nx_raddr = f_q;
    pv_we = 1'b0; pv_waddr = f_q; pv_wdata = NIL; pv_raddr = f_q;
    st_we = 1'b0; st_waddr = f_q; st_wdata = {FS_FREE, OW'(0)}; st_raddr = f_q;

    unique case (state_q)
      S_INIT: begin
        // Clearing pass: frame i links to i + 1, nothing owned, all free.
        nx_we = 1'b1; nx_waddr = clr_q; nx_wdata = LW'(clr_q) + LW'(1);
        pv_we = 1'b1; pv_waddr = clr_q;
        st_we = 1'b1; st_waddr = clr_q;
        if (clr_q == IW'(NUM_FRAMES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_page_d   = 32'd0;
          res_status_d = ST_OK;
          res_freed_d  = 11'd0;
          state_d      = S_RESP;
          unique case (op_i)
            OP_ALLOC: begin
              if (!(own_none || own_ok)) begin
                res_status_d = ST_BAD_OWNER;
              end else if (free_head_q == NIL) begin
                res_status_d = ST_POOL_EMPTY;
              end else begin
                f_d      = free_head_q[IW-1:0];
                o_d      = oidx;
                owned_d  = own_ok;
                nx_raddr = free_head_q[IW-1:0];
                state_d  = S_ALLOC;
              end
            end
            OP_FREE: begin
              if (!in_pool) begin
                res_status_d = ST_BAD_ADDRESS;
              end else begin
                f_d      = frame;
                nx_raddr = frame;
                pv_raddr = frame;
                st_raddr = frame;
                state_d  = S_FREE;
              end
            end
            OP_FREE_ALL: begin
              if (!own_ok) begin
                res_status_d = ST_BAD_OWNER;
              end else begin
                owner_head_d[oidx] = NIL;
                cnt_d = '0;
                if (head != NIL) begin
                  f_d      = head[IW-1:0];
                  nx_raddr = head[IW-1:0];
                  state_d  = S_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        // Pop the head; link an owned frame in front of its owner's list.
        free_head_d = nx_rdata;
        h_d         = owner_head_q[o_q];
        nx_we       = 1'b1;
        nx_wdata    = owned_q ? owner_head_q[o_q] : NIL;
        pv_we       = 1'b1;
        st_we       = 1'b1;
        st_wdata    = owned_q ? {FS_OWNED, o_q} : {FS_UNOWNED, OW'(0)};
        if (owned_q) begin
          owner_head_d[o_q] = LW'(f_q);
        end
        res_page_d = pool_base_q + (32'(f_q) << FRAME_SHIFT);
        state_d    = (owned_q && owner_head_q[o_q] != NIL) ? S_LINK : S_RESP;
      end
      S_LINK: begin
        pv_we    = 1'b1;
        pv_waddr = h_q[IW-1:0];
        pv_wdata = LW'(f_q);
        state_d  = S_RESP;
      end
      S_FREE: begin
        if (st_rdata[SW-1 -: 2] == FS_FREE) begin
          res_status_d = ST_NOT_ALLOC;
          state_d      = S_RESP;
        end else begin
          if (st_rdata[SW-1 -: 2] == FS_OWNED) begin
            // Unlink from the owner's list.
            if (pv_rdata != NIL) begin
              nx_we    = 1'b1;
              nx_waddr = pv_rdata[IW-1:0];
              nx_wdata = nx_rdata;
            end else begin
              owner_head_d[st_rdata[OW-1:0]] = nx_rdata;
            end
            if (nx_rdata != NIL) begin
              pv_we    = 1'b1;
              pv_waddr = nx_rdata[IW-1:0];
              pv_wdata = pv_rdata;
            end
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        nx_we = 1'b1; nx_wdata = free_head_q;
        pv_we = 1'b1;
        st_we = 1'b1;
        free_head_d = LW'(f_q);
        state_d     = S_RESP;
      end
      S_WALK: begin
        // Push this frame and fetch the link of the next one in the same cycle.
        nx_we = 1'b1; nx_wdata = free_head_q;
        pv_we = 1'b1;
        st_we = 1'b1;
        free_head_d = LW'(f_q);
        cnt_d       = cnt_inc;
        if (nx_rdata != NIL) begin
          f_d      = nx_rdata[IW-1:0];
          nx_raddr = nx_rdata[IW-1:0];
        end else begin
          res_freed_d = 11'(cnt_inc);
          state_d     = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_page_d   = res_page_q;
          out_status_d = res_status_q;
          out_freed_d  = res_freed_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      pool_base_q <= 32'h0010_0000;
      free_head_q <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_OWNERS; i++) begin
        owner_head_q[i] <= NIL;
      end
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      owner_head_q <= owner_head_d;
      if (cfg_valid_i) begin
        pool_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q          <= f_d;
    o_q          <= o_d;
    owned_q      <= owned_d;
    h_q          <= h_d;
    res_page_q   <= res_page_d;
    res_status_q <= res_status_d;
    res_freed_q  <= res_freed_d;
    out_page_q   <= out_page_d;
    out_status_q <= out_status_d;
    out_freed_q  <= out_freed_d;
  end

  pfa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  pfa_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );

  pfa_ram #(.WIDTH(SW), .DEPTH(NUM_FRAMES)) u_status_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

endmodule

>>> rtl/core/pfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg.
module pfa_checker
  import pfa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] page_address_o,
  input logic [2:0]  status_o,
  input logic [10:0] pages_freed_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(page_address_o) && $stable(pages_freed_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_POOL_EMPTY
      || status_o == ST_BAD_ADDRESS || status_o == ST_NOT_ALLOC
      || status_o == ST_BAD_OWNER)
    else $error("status code out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> page_address_o == 32'd0 && pages_freed_o == 11'd0)
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pages_freed_o != 11'd0 |-> page_address_o == 32'd0)
    else $error("free_all result carries a page address");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .page_address_o, .status_o, .pages_freed_o
);
